// ===== rtl/actq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actq_pkg: shared types and codes of the box table
// Request and response payloads, the stored box layout, operation and status
// codes.
// ----------------------------------------------------------------------------
package actq_pkg;

	// Operation codes of a request.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_MOVE   = 2'd2;
	localparam logic [1:0] OP_CHECK  = 2'd3;

	// Status codes of a response.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	// One axis-aligned box, signed Q8.8 corners.
	typedef struct packed {
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] min_z;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
		logic signed [15:0] max_z;
	} box_t;

	// One table entry as held in the slot memory.
	typedef struct packed {
		logic [7:0] entity_id;
		box_t       box;
	} slot_t;

	// Request payload.
	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         entity_id;
		logic signed [15:0] min_x;
		logic signed [15:0] min_y;
		logic signed [15:0] min_z;
		logic signed [15:0] max_x;
		logic signed [15:0] max_y;
		logic signed [15:0] max_z;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic signed [15:0] slid_x;
		logic signed [15:0] slid_y;
		logic signed [15:0] slid_z;
		logic               hit;
		logic [1:0]         status;
	} rsp_t;

endpackage

// ===== rtl/actq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module actq_ram #(
	parameter int WIDTH = 104,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [WIDTH-1:0]       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/actq_overlap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actq_overlap: inclusive box overlap comparator
// The one compare unit shared by the check and move-and-slide scans.
// ----------------------------------------------------------------------------
module actq_overlap (
	input  actq_pkg::box_t stored,
	input  actq_pkg::box_t query,
	output logic           overlap
);

	logic sep_x;
	logic sep_y;
	logic sep_z;

	// Two boxes are apart when one axis shows a gap; touching counts as overlap.
	assign sep_x = (stored.max_x < query.min_x) || (stored.min_x > query.max_x);
	assign sep_y = (stored.max_y < query.min_y) || (stored.min_y > query.max_y);
	assign sep_z = (stored.max_z < query.min_z) || (stored.min_z > query.max_z);

	assign overlap = !(sep_x || sep_y || sep_z);

endmodule

// ===== rtl/aabb_collision_table_query.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collision_table_query: table of axis-aligned boxes with overlap query
// Add, remove, overlap check and move-and-slide over a table of tagged boxes.
// ----------------------------------------------------------------------------
// The block handles one request at a time and lowers req_ready until it has
// finished. Check, remove and move-and-slide walk the table slot by slot from
// slot 0, reading each slot from the slot memory ahead of its compare, and
// stop early at the first match: check and move-and-slide use the single
// overlap comparator, remove compares the entity id. Add searches the valid
// bits from slot 0 for the lowest free slot. Move-and-slide makes one table
// pass per axis, after a step that shifts the query box along that axis.
// The response sits in an output register, so the next request is taken
// while it waits. Valid bits are flip flops cleared by reset; no clearing
// pass is needed.
module aabb_collision_table_query #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  actq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output actq_pkg::rsp_t   rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADD  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	// Saturating Q8.8 add of a box edge and a velocity.
	function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
		logic signed [15:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			return s[16] ? 16'sh8000 : 16'sh7fff;
		end
		return s[15:0];
	endfunction

	// Query box taken from a request.
	function automatic actq_pkg::box_t req_box(actq_pkg::req_t r);
		actq_pkg::box_t b;
		b.min_x = r.min_x;
		b.min_y = r.min_y;
		b.min_z = r.min_z;
		b.max_x = r.max_x;
		b.max_y = r.max_y;
		b.max_z = r.max_z;
		return b;
	endfunction

	state_t            state_q;
	actq_pkg::req_t    req_q;
	actq_pkg::box_t    qbox_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IW-1:0]     idx_q;
	logic              issue_done_q;
	logic              cmp_vld_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic [1:0]        axis_q;
	logic signed [15:0] slid_x_q;
	logic signed [15:0] slid_y_q;
	logic signed [15:0] slid_z_q;
	logic              hit_q;
	logic [1:0]        status_q;
	logic              rsp_valid_q;
	actq_pkg::rsp_t    rsp_q;

	logic              ram_we;
	logic              ram_re;
	actq_pkg::slot_t   wr_slot;
	logic [$bits(actq_pkg::slot_t)-1:0] ram_rdata;
	actq_pkg::slot_t   rd_slot;
	logic              box_hit;
	logic              match;
	logic              pass_end;
	logic              rsp_load;
	logic signed [15:0] vel_axis;
	actq_pkg::box_t    shifted_box;

	// Slot memory holding id and box of every entry.
	assign wr_slot.entity_id = req_q.entity_id;
	assign wr_slot.box       = req_box(req_q);
	assign ram_we = (state_q == ST_ADD) && !valid_q[idx_q];

	actq_ram #(
		.WIDTH ($bits(actq_pkg::slot_t)),
		.DEPTH (TABLE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_slot),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_slot = actq_pkg::slot_t'(ram_rdata);

	// Shared overlap comparator.
	actq_overlap u_overlap (
		.stored  (rd_slot.box),
		.query   (qbox_q),
		.overlap (box_hit)
	);

	// Compare stage of the scan: the slot read last cycle is tested now.
	always_comb begin
		if (req_q.op == actq_pkg::OP_REMOVE) begin
			match = cmp_vld_s1 && valid_q[cmp_idx_s1] &&
				(rd_slot.entity_id == req_q.entity_id);
		end else begin
			match = cmp_vld_s1 && valid_q[cmp_idx_s1] && box_hit;
		end
	end

	assign pass_end = (state_q == ST_SCAN) && cmp_vld_s1 && (match || cmp_idx_s1 == LAST);
	assign ram_re   = (state_q == ST_SCAN) && !issue_done_q && !pass_end;

	// Velocity of the current axis and the query box shifted along it.
	always_comb begin
		shifted_box = req_box(req_q);
		case (axis_q)
			AXIS_X: begin
				vel_axis = req_q.vel_x;
				shifted_box.min_x = sat_add(req_q.min_x, req_q.vel_x);
				shifted_box.max_x = sat_add(req_q.max_x, req_q.vel_x);
			end
			AXIS_Y: begin
				vel_axis = req_q.vel_y;
				shifted_box.min_y = sat_add(req_q.min_y, req_q.vel_y);
				shifted_box.max_y = sat_add(req_q.max_y, req_q.vel_y);
			end
			default: begin
				vel_axis = req_q.vel_z;
				shifted_box.min_z = sat_add(req_q.min_z, req_q.vel_z);
				shifted_box.max_z = sat_add(req_q.max_z, req_q.vel_z);
			end
		endcase
	end

	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			axis_q       <= AXIS_X;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q        <= '0;
					issue_done_q <= 1'b0;
					cmp_vld_s1   <= 1'b0;
					axis_q       <= AXIS_X;
					if (req_valid) begin
						case (req.op)
							actq_pkg::OP_ADD:  state_q <= ST_ADD;
							actq_pkg::OP_MOVE: state_q <= ST_PREP;
							default:           state_q <= ST_SCAN;
						endcase
					end
				end
				ST_ADD: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						state_q        <= ST_FIN;
					end else if (idx_q == LAST) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_PREP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// No read is issued at the end of a pass, so the compare
					// stage empties by itself.
					cmp_vld_s1 <= ram_re;
					if (ram_re) begin
						idx_q <= idx_q + IW'(1);
						if (idx_q == LAST) begin
							issue_done_q <= 1'b1;
						end
					end
					if (pass_end) begin
						idx_q        <= '0;
						issue_done_q <= 1'b0;
						if (req_q.op == actq_pkg::OP_REMOVE && match) begin
							valid_q[cmp_idx_s1] <= 1'b0;
						end
						if (req_q.op == actq_pkg::OP_MOVE && axis_q != AXIS_Z) begin
							axis_q  <= axis_q + 2'd1;
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: captured request, query box and result fields.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q    <= req;
					qbox_q   <= req_box(req);
					slid_x_q <= '0;
					slid_y_q <= '0;
					slid_z_q <= '0;
					hit_q    <= 1'b0;
					status_q <= actq_pkg::STATUS_OK;
				end
			end
			ST_ADD: begin
				if (!valid_q[idx_q]) begin
					status_q <= actq_pkg::STATUS_OK;
				end else if (idx_q == LAST) begin
					status_q <= actq_pkg::STATUS_FULL;
				end
			end
			ST_PREP: begin
				qbox_q <= shifted_box;
			end
			ST_SCAN: begin
				if (pass_end) begin
					case (req_q.op)
						actq_pkg::OP_REMOVE: begin
							status_q <= match ? actq_pkg::STATUS_OK
								: actq_pkg::STATUS_NOT_FOUND;
						end
						actq_pkg::OP_MOVE: begin
							case (axis_q)
								AXIS_X:  slid_x_q <= match ? 16'sd0 : vel_axis;
								AXIS_Y:  slid_y_q <= match ? 16'sd0 : vel_axis;
								default: slid_z_q <= match ? 16'sd0 : vel_axis;
							endcase
						end
						default: begin
							hit_q <= match;
						end
					endcase
				end
			end
			ST_FIN: begin
				if (rsp_load) begin
					rsp_q.slid_x <= slid_x_q;
					rsp_q.slid_y <= slid_y_q;
					rsp_q.slid_z <= slid_z_q;
					rsp_q.hit    <= hit_q;
					rsp_q.status <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/actq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actq_checker: port-level assertions for the box table
// Watches the request and response ports and is bound to the top level.
// ----------------------------------------------------------------------------
module actq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input actq_pkg::rsp_t rsp
);

	// A held response keeps its value until the transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// The block works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// A FULL or NOT_FOUND status never comes with slide or hit data.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != actq_pkg::STATUS_OK |->
		!rsp.hit && rsp.slid_x == 16'sd0 && rsp.slid_y == 16'sd0 && rsp.slid_z == 16'sd0)
		else $error("error status mixed with query result");

	// A check hit never carries slide velocities.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |->
		rsp.slid_x == 16'sd0 && rsp.slid_y == 16'sd0 && rsp.slid_z == 16'sd0)
		else $error("hit with nonzero velocity");

	// Only defined status codes leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == actq_pkg::STATUS_OK ||
		rsp.status == actq_pkg::STATUS_FULL || rsp.status == actq_pkg::STATUS_NOT_FOUND)
		else $error("undefined status code");

endmodule

bind aabb_collision_table_query actq_checker u_actq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
